### rtl/dpf_pkg.sv
// Shared types, constants and CRC helpers for the packet framer.
// Used by dpf_front, dpf_cmdq, dpf_back and data_packet_framer_crc32.
`timescale 1ns / 1ps
`default_nettype none

package dpf_pkg;

	localparam int unsigned MAX_PAYLOAD = 512;
	localparam int unsigned REMAIN_W    = 10;

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam int unsigned CMDQ_DEPTH = 4;
	localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);
	localparam int unsigned CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

	// back-end step counter: header bytes, header CRC, payload CRC trailer
	localparam int unsigned STEP_W = 4;
	localparam logic [STEP_W-1:0] HDR_LAST_BYTE_STEP = 4'd7;
	localparam logic [STEP_W-1:0] HDR_LAST_STEP      = 4'd11;
	localparam logic [STEP_W-1:0] TRAILER_LAST_STEP  = 4'd4;

	typedef struct packed {
		logic        mode;
		logic [7:0]  seq_number;
		logic [4:0]  window;
		logic [15:0] payload_length;
		logic [31:0] timestamp;
		logic [7:0]  data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       end_of_packet;
		logic       status;
	} out_item_t;

	typedef enum logic [1:0] {
		CMD_ERR,
		CMD_HDR,
		CMD_DATA
	} cmd_kind_t;

	// HDR: payload holds the 8 header bytes, MSB first.
	// DATA: payload[7:0] holds the byte. last marks packet end.
	typedef struct packed {
		cmd_kind_t   kind;
		logic        last;
		logic [63:0] payload;
	} cmd_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// byte idx 0 is the most significant
	function automatic logic [7:0] byte_of_u64(input logic [63:0] v, input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = v[63:56];
			3'd1: r = v[55:48];
			3'd2: r = v[47:40];
			3'd3: r = v[39:32];
			3'd4: r = v[31:24];
			3'd5: r = v[23:16];
			3'd6: r = v[15:8];
			default: r = v[7:0];
		endcase
		return r;
	endfunction

	function automatic logic [7:0] byte_of_u32(input logic [31:0] v, input logic [1:0] idx);
		logic [7:0] r;
		case (idx)
			2'd0: r = v[31:24];
			2'd1: r = v[23:16];
			2'd2: r = v[15:8];
			default: r = v[7:0];
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/data_packet_framer_crc32.sv
// Packet framer with CRC-32 over header and payload.
// An item is registered in the command queue and then in the output register.
// Throughput: 1 output byte per cycle while pop keeps up, set by the single
// byte lane; a valid header gives 12 bytes, a final payload byte 5, others 1.
// A 4-entry command queue lets the front keep accepting during header bursts.
// Reset (arst_n low, asynchronous): no packet open, queues empty, type code 1.
`timescale 1ns / 1ps
`default_nettype none

module data_packet_framer_crc32 (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire dpf_pkg::in_item_t  item,
	output logic                    empty,
	input  wire logic               pop,
	output dpf_pkg::out_item_t      result,
	input  wire logic               cfg_wr_en,
	input  wire logic [1:0]         cfg_wr_data
);

	logic          accept;
	logic          cmd_push;
	dpf_pkg::cmd_t cmd;
	logic          head_valid;
	dpf_pkg::cmd_t head_cmd;
	logic          cmd_pop;

	assign accept = push && !full;

	dpf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.item       (item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd_push   (cmd_push),
		.cmd        (cmd)
	);

	dpf_cmdq u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_cmd  (cmd),
		.full      (full),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.pop       (cmd_pop)
	);

	dpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(head_valid),
		.head_cmd  (head_cmd),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.result    (result),
		.pop       (pop)
	);

endmodule

`default_nettype wire

### rtl/dpf_front.sv
// Front end: accepts input items, tracks the open packet and classifies
// each item into a command for the back end. Depends on dpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpf_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire dpf_pkg::in_item_t item,
	input  wire logic             cfg_wr_en,
	input  wire logic [1:0]       cfg_wr_data,
	output logic                  cmd_push,
	output dpf_pkg::cmd_t         cmd
);

	logic                         open_q;
	logic [dpf_pkg::REMAIN_W-1:0] remain_q;
	logic [1:0]                   type_q;

	logic                         too_long;
	logic [dpf_pkg::REMAIN_W-1:0] remain_dec;

	assign too_long   = item.payload_length > 16'(dpf_pkg::MAX_PAYLOAD);
	assign remain_dec = remain_q - 1'b1;

	always_comb begin
		cmd_push = 1'b0;
		cmd      = '{kind: dpf_pkg::CMD_DATA, last: 1'b0, payload: '0};
		if (!item.mode) begin
			cmd_push = accept;
			if (too_long) begin
				cmd.kind = dpf_pkg::CMD_ERR;
				cmd.last = 1'b1;
			end else begin
				cmd.kind    = dpf_pkg::CMD_HDR;
				cmd.last    = item.payload_length == 16'd0;
				// flag bit (bit 5) is always zero
				cmd.payload = {type_q, 1'b0, item.window, item.seq_number,
				               item.payload_length, item.timestamp};
			end
		end else begin
			// bytes outside a packet are dropped
			cmd_push    = accept && open_q;
			cmd.kind    = dpf_pkg::CMD_DATA;
			cmd.last    = remain_dec == '0;
			cmd.payload = {56'd0, item.data_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			remain_q <= '0;
			type_q   <= 2'd1;
		end else begin
			if (cfg_wr_en) begin
				type_q <= cfg_wr_data;
			end
			if (accept) begin
				if (!item.mode) begin
					open_q   <= !too_long && (item.payload_length != 16'd0);
					remain_q <= too_long ? '0 : item.payload_length[dpf_pkg::REMAIN_W-1:0];
				end else if (open_q) begin
					remain_q <= remain_dec;
					if (remain_dec == '0) begin
						open_q <= 1'b0;
					end
				end
			end
		end
	end

`ifndef ASSERT_OFF
	a_open_has_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> remain_q != '0)
		else $error("open packet with zero bytes remaining");

	a_data_only_open: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_push && cmd.kind == dpf_pkg::CMD_DATA) |-> open_q)
		else $error("data command pushed outside a packet");

	a_err_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_push && cmd.kind == dpf_pkg::CMD_ERR) |=> !open_q)
		else $error("packet left open after length error");
`endif

endmodule

`default_nettype wire

### rtl/dpf_cmdq.sv
// Short command queue between front and back end, register based.
// Depends on dpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpf_cmdq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire dpf_pkg::cmd_t push_cmd,
	output logic               full,
	output logic               head_valid,
	output dpf_pkg::cmd_t      head_cmd,
	input  wire logic          pop
);

	dpf_pkg::cmd_t               slot_q [dpf_pkg::CMDQ_DEPTH];
	logic [dpf_pkg::CMDQ_AW-1:0] wr_ptr_q;
	logic [dpf_pkg::CMDQ_AW-1:0] rd_ptr_q;
	logic [dpf_pkg::CMDQ_CW-1:0] count_q;

	assign full       = count_q == dpf_pkg::CMDQ_CW'(dpf_pkg::CMDQ_DEPTH);
	assign head_valid = count_q != '0;
	assign head_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("command queue underflow");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= dpf_pkg::CMDQ_CW'(dpf_pkg::CMDQ_DEPTH))
		else $error("command queue count out of range");
`endif

endmodule

`default_nettype wire

### rtl/dpf_back.sv
// Back end: serializes the command at the queue head into output bytes,
// runs header and payload CRC-32 and holds the output register.
// Depends on dpf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpf_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           head_valid,
	input  wire dpf_pkg::cmd_t  head_cmd,
	output logic                cmd_pop,
	output logic                empty,
	output dpf_pkg::out_item_t  result,
	input  wire logic           pop
);

	logic [dpf_pkg::STEP_W-1:0] step_q;
	logic [31:0]                hcrc_q;
	logic [31:0]                pcrc_q;
	logic                       out_valid_q;
	dpf_pkg::out_item_t         out_q;

	logic                       advance;
	logic                       fire;
	logic                       done;
	dpf_pkg::out_item_t         nxt;
	logic [31:0]                hcrc_d;
	logic [31:0]                pcrc_d;
	logic [dpf_pkg::STEP_W-1:0] trl_idx;

	assign advance = !out_valid_q || pop;
	assign fire    = head_valid && advance;
	assign cmd_pop = fire && done;
	assign empty   = !out_valid_q;
	assign result  = out_q;
	assign trl_idx = step_q - 1'b1;

	always_comb begin
		nxt    = '{out_byte: 8'd0, end_of_packet: 1'b0, status: 1'b0};
		done   = 1'b0;
		hcrc_d = hcrc_q;
		pcrc_d = pcrc_q;
		unique case (head_cmd.kind)
			dpf_pkg::CMD_ERR: begin
				nxt.end_of_packet = 1'b1;
				nxt.status        = 1'b1;
				done              = 1'b1;
				pcrc_d            = dpf_pkg::CRC_INIT;
			end
			dpf_pkg::CMD_HDR: begin
				if (step_q <= dpf_pkg::HDR_LAST_BYTE_STEP) begin
					nxt.out_byte = dpf_pkg::byte_of_u64(head_cmd.payload, step_q[2:0]);
					hcrc_d = dpf_pkg::crc_byte((step_q == '0) ? dpf_pkg::CRC_INIT : hcrc_q,
					                           nxt.out_byte);
				end else begin
					nxt.out_byte = dpf_pkg::byte_of_u32(~hcrc_q, step_q[1:0]);
				end
				done              = step_q == dpf_pkg::HDR_LAST_STEP;
				nxt.end_of_packet = done && head_cmd.last;
				pcrc_d            = dpf_pkg::CRC_INIT;
			end
			dpf_pkg::CMD_DATA: begin
				if (step_q == '0) begin
					nxt.out_byte = head_cmd.payload[7:0];
					pcrc_d       = dpf_pkg::crc_byte(pcrc_q, head_cmd.payload[7:0]);
					done         = !head_cmd.last;
				end else begin
					nxt.out_byte      = dpf_pkg::byte_of_u32(~pcrc_q, trl_idx[1:0]);
					done              = step_q == dpf_pkg::TRAILER_LAST_STEP;
					nxt.end_of_packet = done;
					if (done) begin
						pcrc_d = dpf_pkg::CRC_INIT;
					end
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			pcrc_q      <= dpf_pkg::CRC_INIT;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				step_q <= done ? '0 : step_q + 1'b1;
				pcrc_q <= pcrc_d;
			end
			if (advance) begin
				out_valid_q <= head_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q  <= nxt;
			hcrc_q <= hcrc_d;
		end
	end

`ifndef ASSERT_OFF
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= dpf_pkg::HDR_LAST_STEP)
		else $error("serializer step out of range");

	a_busy_has_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(step_q != '0) |-> head_valid)
		else $error("command left the queue mid-serialization");

	a_trailer_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && head_cmd.kind == dpf_pkg::CMD_DATA) |->
		(step_q <= dpf_pkg::TRAILER_LAST_STEP))
		else $error("payload trailer step out of range");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		(head_valid && head_cmd.kind == dpf_pkg::CMD_ERR) |-> (step_q == '0))
		else $error("error command spans more than one byte");
`endif

endmodule

`default_nettype wire

### tb/sv/data_packet_framer_crc32_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for data_packet_framer_crc32: a directed stimulus table, then
// random packets, with a CRC-32 framing predictor checked byte by byte.
// Depends on dpf_pkg (item types, MAX_PAYLOAD) and the framer RTL.

module data_packet_framer_crc32_tb;

	localparam int          DRAIN_CYCLES    = 12;
	localparam int          HOLD_CYCLES     = 400;
	localparam int          TIMEOUT_NS      = 2_000_000;
	localparam int          MAX_ERR_LINES   = 200;
	localparam logic [31:0] CRC32_POLY      = 32'hEDB88320;
	localparam logic [1:0]  TYPE_CODE_RESET = 2'd1;

	localparam logic MODE_HEADER  = 1'b0;
	localparam logic MODE_PAYLOAD = 1'b1;
	localparam logic ST_OK        = 1'b0;
	localparam logic ST_TOO_LONG  = 1'b1;

	// how a directed row is checked
	localparam int PREDICTED  = -1;
	localparam int TYPED_NONE = 0;
	localparam int TYPED_ONE  = 1;

	localparam dpf_pkg::out_item_t ERR_RESULT = '{out_byte: 8'h00, end_of_packet: 1'b1,
		status: ST_TOO_LONG};
	localparam dpf_pkg::out_item_t NO_TYPED   = '0;

	typedef struct {
		dpf_pkg::in_item_t  it;
		int                 typed_n;
		dpf_pkg::out_item_t typed;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               push;
	logic               full;
	dpf_pkg::in_item_t  item_bus;
	logic               empty;
	logic               pop;
	dpf_pkg::out_item_t result_bus;
	logic               cfg_wr_en;
	logic [1:0]         cfg_wr_data;

	// predictor state
	logic [1:0]  type_code;
	logic [31:0] pay_crc;
	logic [9:0]  bytes_left;
	logic        in_packet;

	dpf_pkg::out_item_t expected_q[$];
	stim_row_t          stim_rows[$];
	int                 errors       = 0;
	int                 items_framed = 0;
	int                 tx_idle_pct  = 23;
	int                 rx_idle_pct  = 84;
	bit                 hold_req     = 1'b0;

	data_packet_framer_crc32 dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.item       (item_bus),
		.empty      (empty),
		.pop        (pop),
		.result     (result_bus),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#TIMEOUT_NS;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic flag_error(input string what);
		if (errors < MAX_ERR_LINES)
			$display("ERROR @%0t: %s", $time, what);
		errors++;
	endtask

	// bit-serial reflected CRC-32, LSB of the byte first
	function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
		logic fb;
		for (int i = 0; i < 8; i++) begin
			fb = c[0] ^ b[i];
			c = c >> 1;
			if (fb)
				c = c ^ CRC32_POLY;
		end
		return c;
	endfunction

	function automatic void queue_byte(input bit record, input logic [7:0] b, input logic eop,
		input logic st);
		dpf_pkg::out_item_t r;
		r.out_byte      = b;
		r.end_of_packet = eop;
		r.status        = st;
		if (record)
			expected_q = {expected_q, r};
	endfunction

	function automatic void queue_word(input bit record, input logic [31:0] w, input logic last);
		queue_byte(record, w[31:24], 1'b0, ST_OK);
		queue_byte(record, w[23:16], 1'b0, ST_OK);
		queue_byte(record, w[15:8], 1'b0, ST_OK);
		queue_byte(record, w[7:0], last, ST_OK);
	endfunction

	// Advances the framer state by one accepted item; returns the number of
	// output bytes it causes and queues them when record is set.
	function automatic int frame_item(input dpf_pkg::in_item_t it, input bit record);
		logic [7:0]  hb [8];
		logic [31:0] hcrc;
		if (it.mode == MODE_HEADER) begin
			in_packet  = 1'b0;
			bytes_left = '0;
			pay_crc    = '1;
			if (it.payload_length > dpf_pkg::MAX_PAYLOAD) begin
				queue_byte(record, 8'h00, 1'b1, ST_TOO_LONG);
				return 1;
			end
			hb[0] = {type_code, 1'b0, it.window};   // flag bit always zero
			hb[1] = it.seq_number;
			hb[2] = it.payload_length[15:8];
			hb[3] = it.payload_length[7:0];
			hb[4] = it.timestamp[31:24];
			hb[5] = it.timestamp[23:16];
			hb[6] = it.timestamp[15:8];
			hb[7] = it.timestamp[7:0];
			hcrc = '1;
			foreach (hb[i]) begin
				hcrc = crc32_step(hcrc, hb[i]);
				queue_byte(record, hb[i], 1'b0, ST_OK);
			end
			queue_word(record, ~hcrc, it.payload_length == 16'd0);
			if (it.payload_length != 16'd0) begin
				in_packet  = 1'b1;
				bytes_left = it.payload_length[9:0];
			end
			return 12;
		end
		if (!in_packet)
			return 0;
		pay_crc = crc32_step(pay_crc, it.data_byte);
		queue_byte(record, it.data_byte, 1'b0, ST_OK);
		bytes_left = bytes_left - 10'd1;
		if (bytes_left != '0)
			return 1;
		in_packet = 1'b0;
		queue_word(record, ~pay_crc, 1'b1);
		pay_crc = '1;
		return 5;
	endfunction

	function automatic void add_row(input logic mode, input logic [7:0] seq,
		input logic [4:0] win, input logic [15:0] len, input logic [31:0] ts,
		input logic [7:0] db, input int typed_n, input dpf_pkg::out_item_t typed);
		stim_row_t r;
		r.it.mode           = mode;
		r.it.seq_number     = seq;
		r.it.window         = win;
		r.it.payload_length = len;
		r.it.timestamp      = ts;
		r.it.data_byte      = db;
		r.typed_n           = typed_n;
		r.typed             = typed;
		stim_rows = {stim_rows, r};
	endfunction

	function automatic dpf_pkg::in_item_t random_header(input logic [15:0] len);
		dpf_pkg::in_item_t it;
		it.mode           = MODE_HEADER;
		it.seq_number     = 8'($urandom);
		it.window         = 5'($urandom);
		it.payload_length = len;
		it.timestamp      = $urandom;
		it.data_byte      = 8'($urandom);
		return it;
	endfunction

	function automatic dpf_pkg::in_item_t random_byte();
		dpf_pkg::in_item_t it;
		it      = random_header(16'($urandom));   // junk in the unused fields
		it.mode = MODE_PAYLOAD;
		return it;
	endfunction

	// One input transaction. push is left high on return so back-to-back
	// items need no second assignment in the same step.
	task automatic send_item(input dpf_pkg::in_item_t it, input int typed_n,
		input dpf_pkg::out_item_t typed);
		int n;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push     <= 1'b1;
		item_bus <= it;
		@(posedge clk);
		while (full)
			@(posedge clk);
		n = frame_item(it, typed_n == PREDICTED);
		if (typed_n == TYPED_ONE)
			expected_q = {expected_q, typed};
		if (n > 0)
			items_framed++;
	endtask

	task automatic random_packet();
		int pick;
		int size_pick;
		int len;
		int cnt;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			send_item(random_byte(), PREDICTED, NO_TYPED);
			return;
		end
		if (pick < 18) begin
			send_item(random_header(16'($urandom_range(dpf_pkg::MAX_PAYLOAD + 1, 65535))),
				PREDICTED, NO_TYPED);
			return;
		end
		size_pick = $urandom_range(0, 9);
		if (size_pick == 0)
			len = 0;
		else if (size_pick == 9)
			len = $urandom_range(9, 40);
		else
			len = $urandom_range(1, 8);
		cnt = len;
		// truncated packet: the next header drops it
		if (pick < 26 && len > 0)
			cnt = $urandom_range(0, len - 1);
		send_item(random_header(16'(len)), PREDICTED, NO_TYPED);
		repeat (cnt)
			send_item(random_byte(), PREDICTED, NO_TYPED);
	endtask

	task automatic settle();
		push <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
	endtask

	task automatic write_type_code(input logic [1:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		type_code = v;
	endtask

	task automatic check_result(input dpf_pkg::out_item_t got);
		dpf_pkg::out_item_t want;
		if (expected_q.size() == 0) begin
			flag_error($sformatf("unexpected result byte %02h eop %0b status %0b",
				got.out_byte, got.end_of_packet, got.status));
			return;
		end
		want = expected_q.pop_front();
		if (got.out_byte !== want.out_byte)
			flag_error($sformatf("out_byte %02h, want %02h", got.out_byte, want.out_byte));
		if (got.end_of_packet !== want.end_of_packet)
			flag_error($sformatf("end_of_packet %0b, want %0b (byte %02h)",
				got.end_of_packet, want.end_of_packet, want.out_byte));
		if (got.status !== want.status)
			flag_error($sformatf("status %0b, want %0b", got.status, want.status));
	endtask

	// result side: one pop decision per cycle, plus one long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		pop <= 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty)
				check_result(result_bus);
			if (hold_req && hold_left == 0) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		arst_n      <= 1'b0;
		push        <= 1'b0;
		item_bus    <= '0;
		cfg_wr_en   <= 1'b0;
		cfg_wr_data <= '0;
		type_code  = TYPE_CODE_RESET;
		pay_crc    = '1;
		bytes_left = '0;
		in_packet  = 1'b0;

		add_row(MODE_PAYLOAD, 8'hFF, 5'h1F, 16'hFFFF, 32'hFFFFFFFF, 8'hA5, TYPED_NONE, NO_TYPED);
		add_row(MODE_HEADER, 8'h00, 5'h00, 16'd513, 32'h0, 8'h00, TYPED_ONE, ERR_RESULT);
		add_row(MODE_HEADER, 8'hFF, 5'h1F, 16'hFFFF, 32'hFFFFFFFF, 8'hFF, TYPED_ONE, ERR_RESULT);
		add_row(MODE_HEADER, 8'h00, 5'h00, 16'd0, 32'h0, 8'h00, PREDICTED, NO_TYPED);
		add_row(MODE_HEADER, 8'hFF, 5'h1F, 16'd0, 32'hFFFFFFFF, 8'hFF, PREDICTED, NO_TYPED);
		add_row(MODE_HEADER, 8'h3C, 5'h15, 16'd1, 32'h01234567, 8'h00, PREDICTED, NO_TYPED);
		add_row(MODE_PAYLOAD, 8'h00, 5'h00, 16'h0, 32'h0, 8'h00, PREDICTED, NO_TYPED);
		add_row(MODE_HEADER, 8'h81, 5'h0A, 16'd512, 32'h89ABCDEF, 8'h00, PREDICTED, NO_TYPED);
		add_row(MODE_PAYLOAD, 8'h00, 5'h00, 16'h0, 32'h0, 8'hFF, PREDICTED, NO_TYPED);
		// new header while the max-length packet is still open
		add_row(MODE_HEADER, 8'h7E, 5'h11, 16'd3, 32'hDEADBEEF, 8'h00, PREDICTED, NO_TYPED);
		add_row(MODE_PAYLOAD, 8'hFF, 5'h1F, 16'hFFFF, 32'hFFFFFFFF, 8'h00, PREDICTED, NO_TYPED);
		add_row(MODE_PAYLOAD, 8'h00, 5'h00, 16'h0, 32'h0, 8'hFF, PREDICTED, NO_TYPED);
		add_row(MODE_PAYLOAD, 8'h12, 5'h09, 16'h1234, 32'h55AA55AA, 8'h5A, PREDICTED, NO_TYPED);
		add_row(MODE_PAYLOAD, 8'h00, 5'h00, 16'h0, 32'h0, 8'h11, TYPED_NONE, NO_TYPED);
		add_row(MODE_HEADER, 8'h42, 5'h0F, 16'd2, 32'h00000001, 8'h00, PREDICTED, NO_TYPED);
		add_row(MODE_PAYLOAD, 8'h00, 5'h00, 16'h0, 32'h0, 8'hC3, PREDICTED, NO_TYPED);
		// oversize header drops the open packet
		add_row(MODE_HEADER, 8'h42, 5'h0F, 16'd513, 32'h00000001, 8'h00, TYPED_ONE, ERR_RESULT);
		add_row(MODE_PAYLOAD, 8'h00, 5'h00, 16'h0, 32'h0, 8'h77, TYPED_NONE, NO_TYPED);
		add_row(MODE_HEADER, 8'h00, 5'h1F, 16'd1, 32'h80000000, 8'h00, PREDICTED, NO_TYPED);
		add_row(MODE_PAYLOAD, 8'h00, 5'h00, 16'h0, 32'h0, 8'h80, PREDICTED, NO_TYPED);

		repeat (4)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			send_item(stim_rows[i].it, stim_rows[i].typed_n, stim_rows[i].typed);
		settle();

		write_type_code(2'd3);
		while (items_framed < 65)
			random_packet();
		settle();

		tx_idle_pct = 84;
		rx_idle_pct = 23;
		write_type_code(2'd0);
		while (items_framed < 112)
			random_packet();
		settle();

		// no idling; the result side holds off once so the input backs up
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		write_type_code(2'd2);
		hold_req = 1'b1;
		while (items_framed < 160)
			random_packet();
		settle();

		if (!empty)
			flag_error("result left over after the last expected byte");

		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
